### hdl/cgl_pkg.sv
// ----------------------------------------------------------------------------
// cgl_pkg
// Shared types, codes and sizes for the character map glyph lookup block.
// ----------------------------------------------------------------------------
package cgl_pkg;

  // Default sizes, handed to the top level parameters
  localparam int unsigned MAX_ENTRIES_DEF       = 256;
  localparam int unsigned GLYPH_ARRAY_DEPTH_DEF = 4096;

  // Fixed field widths
  localparam int unsigned CODE_W    = 21;
  localparam int unsigned GLYPH_W   = 16;
  localparam int unsigned INDEX_W   = 12;  // entry_index field, also slot in a token
  localparam int unsigned CNT_W     = 13;  // saturated entry count, up to 4096
  localparam int unsigned WORDS_W   = 16;  // saturated glyph array count, up to 32768
  localparam int unsigned IDX_W     = 24;  // signed glyph array index
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    REQ_SEGMENT = 2'd0,
    REQ_ARRAY   = 2'd1,
    REQ_GROUP   = 2'd2,
    REQ_LOOKUP  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    FMT_NONE    = 2'd0,
    FMT_SEGMENT = 2'd1,
    FMT_GROUP   = 2'd2
  } fmt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_FORMAT = 2'd0,
    CFG_ENTRY_COUNT  = 2'd1,
    CFG_GLYPH_COUNT  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    req_e                       req_type;
    logic [INDEX_W-1:0]         entry_index;
    logic [CODE_W-1:0]          range_first;
    logic [CODE_W-1:0]          range_last;
    logic [GLYPH_W-1:0]         glyph_word;
    logic signed [GLYPH_W-1:0]  id_offset_delta;
    logic [GLYPH_W-1:0]         array_offset;
    logic [CODE_W-1:0]          char_code;
  } req_payload_t;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph_id;
    logic               range_hit;
  } rsp_payload_t;

  // Lookup token walking the cell chain
  typedef struct packed {
    logic               valid;
    logic               hit;
    logic [CODE_W-1:0]  code;
    logic [CODE_W-1:0]  diff;   // code - first of the matching entry
    logic [GLYPH_W-1:0] base;
    logic [GLYPH_W-1:0] roff;
    logic [INDEX_W-1:0] slot;
  } token_t;

  // Entry write broadcast to all cells
  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] slot;
    logic [CODE_W-1:0]  first;
    logic [CODE_W-1:0]  last;
    logic [GLYPH_W-1:0] base;
    logic [GLYPH_W-1:0] roff;
  } entry_wr_t;

  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] addr;
    logic [GLYPH_W-1:0] data;
  } array_wr_t;

endpackage

### hdl/cgl_stream_if.sv
// ----------------------------------------------------------------------------
// cgl_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface cgl_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/cmap_glyph_lookup.sv
// ----------------------------------------------------------------------------
// cmap_glyph_lookup
// Character code to glyph id lookup over a loaded cmap format 4 / 12 table.
// ----------------------------------------------------------------------------
// Writes (segment, group, glyph array word) are stored at their transfer.
// A lookup enters a row of MAX_ENTRIES cells, one per table slot, and moves
// one cell per clock; the first active slot whose range holds the code
// claims it. Three more stages then form the glyph (index math, glyph array
// read, delta add) before the result moves on to the response register.
// One lookup is in flight at a time: req ready drops at a lookup transfer
// and returns once its result has moved into the response register, so a
// waiting response does not block the next request. The glyph array is a
// plain memory with no clear; reads of words never written return whatever
// the memory holds. The user must write configuration only while no lookup
// is outstanding; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module cmap_glyph_lookup import cgl_pkg::*; #(
  parameter int unsigned MAX_ENTRIES       = MAX_ENTRIES_DEF,
  parameter int unsigned GLYPH_ARRAY_DEPTH = GLYPH_ARRAY_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  cgl_stream_if.sink           req_i,
  cgl_stream_if.source         rsp_o
);

  // configuration
  logic [1:0]  fmt_q;
  logic [8:0]  ecount_q;
  logic [12:0] gcount_q;

  logic [CNT_W-1:0]   used_entries;
  logic [WORDS_W-1:0] used_words;

  // request side
  req_payload_t req;
  logic         req_xfer;
  logic         busy_q;

  entry_wr_t entry_wr;
  array_wr_t array_wr;
  token_t    tok [MAX_ENTRIES+1];

  // response side
  logic         res_valid, res_take;
  rsp_payload_t res;
  logic         out_valid_q;
  rsp_payload_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= '0;
      ecount_q <= '0;
      gcount_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TABLE_FORMAT: fmt_q    <= cfg_data_i[1:0];
        CFG_ENTRY_COUNT:  ecount_q <= cfg_data_i[8:0];
        CFG_GLYPH_COUNT:  gcount_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // counts beyond the storage saturate
  assign used_entries = (CNT_W'(ecount_q) > CNT_W'(MAX_ENTRIES)) ?
                        CNT_W'(MAX_ENTRIES) : CNT_W'(ecount_q);
  assign used_words   = (WORDS_W'(gcount_q) > WORDS_W'(GLYPH_ARRAY_DEPTH)) ?
                        WORDS_W'(GLYPH_ARRAY_DEPTH) : WORDS_W'(gcount_q);

  assign req         = req_i.data;
  assign req_i.ready = !busy_q;
  assign req_xfer    = req_i.valid && !busy_q;

  // a group reuses the segment storage: start glyph as base, no range offset
  always_comb begin
    entry_wr.en    = req_xfer && ((req.req_type == REQ_SEGMENT) ||
                                  (req.req_type == REQ_GROUP));
    entry_wr.slot  = req.entry_index;
    entry_wr.first = req.range_first;
    entry_wr.last  = req.range_last;
    if (req.req_type == REQ_GROUP) begin
      entry_wr.base = req.glyph_word;
      entry_wr.roff = '0;
    end else begin
      entry_wr.base = req.id_offset_delta;
      entry_wr.roff = req.array_offset;
    end
    array_wr.en   = req_xfer && (req.req_type == REQ_ARRAY);
    array_wr.addr = req.entry_index;
    array_wr.data = req.glyph_word;
  end

  // token injected at the head of the cell row
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = req_xfer && (req.req_type == REQ_LOOKUP);
    tok[0].code  = req.char_code;
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    cgl_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .wr_i           (entry_wr),
      .used_entries_i (used_entries),
      .tok_i          (tok[g]),
      .tok_o          (tok[g+1])
    );
  end

  cgl_resolve #(
    .GLYPH_ARRAY_DEPTH (GLYPH_ARRAY_DEPTH)
  ) u_resolve (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_i           (array_wr),
    .fmt_i          (fmt_q),
    .used_entries_i (used_entries),
    .used_words_i   (used_words),
    .tok_i          (tok[MAX_ENTRIES]),
    .res_take_i     (res_take),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  // result moves into the response register once it is free
  assign res_take = res_valid && (!out_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (tok[0].valid) begin
        busy_q <= 1'b1;
      end else if (res_take) begin
        busy_q <= 1'b0;
      end
      if (res_take) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

### hdl/cgl_cell.sv
// ----------------------------------------------------------------------------
// cgl_cell
// One slot of the range table; checks the passing token against its range.
// ----------------------------------------------------------------------------
module cgl_cell import cgl_pkg::*; #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  entry_wr_t        wr_i,
  input  logic [CNT_W-1:0] used_entries_i,
  input  token_t           tok_i,
  output token_t           tok_o
);

  logic [CODE_W-1:0]  first_q, last_q;
  logic [GLYPH_W-1:0] base_q, roff_q;
  token_t             tok_d, tok_q;
  logic               match;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.slot == INDEX_W'(CELL_IDX))) begin
      first_q <= wr_i.first;
      last_q  <= wr_i.last;
      base_q  <= wr_i.base;
      roff_q  <= wr_i.roff;
    end
  end

  // first active slot in range claims the token
  assign match = tok_i.valid && !tok_i.hit && (CNT_W'(CELL_IDX) < used_entries_i) &&
                 (tok_i.code >= first_q) && (tok_i.code <= last_q);

  always_comb begin
    tok_d = tok_i;
    if (match) begin
      tok_d.hit  = 1'b1;
      tok_d.diff = tok_i.code - first_q;
      tok_d.base = base_q;
      tok_d.roff = roff_q;
      tok_d.slot = INDEX_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

### hdl/cgl_resolve.sv
// ----------------------------------------------------------------------------
// cgl_resolve
// Glyph array memory and the glyph arithmetic behind the cell chain.
// ----------------------------------------------------------------------------
module cgl_resolve import cgl_pkg::*; #(
  parameter int unsigned GLYPH_ARRAY_DEPTH = GLYPH_ARRAY_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  array_wr_t          wr_i,
  input  logic [1:0]         fmt_i,
  input  logic [CNT_W-1:0]   used_entries_i,
  input  logic [WORDS_W-1:0] used_words_i,
  input  token_t             tok_i,
  input  logic               res_take_i,
  output logic               res_valid_o,
  output rsp_payload_t       res_o
);

  localparam int unsigned AW = (GLYPH_ARRAY_DEPTH > 1) ? $clog2(GLYPH_ARRAY_DEPTH) : 1;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_DIRECT,
    MODE_ARRAY
  } mode_e;

  logic [GLYPH_W-1:0] mem_q [GLYPH_ARRAY_DEPTH];

  // stage 1
  logic               s1_valid_q;
  mode_e              s1_mode_d, s1_mode_q;
  logic               s1_hit_d, s1_hit_q;
  logic [GLYPH_W-1:0] s1_glyph_d, s1_glyph_q;
  logic [GLYPH_W-1:0] s1_base_q;
  logic [IDX_W-1:0]   s1_idx_d, s1_idx_q;
  // stage 2
  logic               s2_valid_q;
  mode_e              s2_mode_q;
  logic               s2_hit_q;
  logic [GLYPH_W-1:0] s2_glyph_q, s2_base_q, s2_rd_q;
  logic               s2_inrange_q;
  // result
  logic               res_valid_q;
  rsp_payload_t       res_d, res_q;

  logic [WORDS_W-1:0] wr_addr_ext;
  logic [AW-1:0]      rd_addr;
  logic               rd_inrange;

  assign wr_addr_ext = WORDS_W'(wr_i.addr);

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_addr_ext < WORDS_W'(GLYPH_ARRAY_DEPTH))) begin
      mem_q[wr_addr_ext[AW-1:0]] <= wr_i.data;
    end
  end

  // stage 1: pick the glyph rule, form the array index
  always_comb begin
    s1_mode_d  = MODE_ZERO;
    s1_hit_d   = 1'b0;
    s1_glyph_d = tok_i.base + tok_i.diff[GLYPH_W-1:0];
    s1_idx_d   = IDX_W'(tok_i.roff[GLYPH_W-1:1]) + IDX_W'(tok_i.diff) +
                 IDX_W'(tok_i.slot) - IDX_W'(used_entries_i);
    if (fmt_i == FMT_GROUP) begin
      s1_hit_d  = tok_i.hit;
      s1_mode_d = tok_i.hit ? MODE_DIRECT : MODE_ZERO;
    end else if (fmt_i == FMT_SEGMENT) begin
      s1_hit_d = tok_i.hit;
      if (!tok_i.hit) begin
        s1_mode_d = MODE_ZERO;
      end else if (tok_i.roff == '0) begin
        s1_mode_d  = MODE_DIRECT;
        s1_glyph_d = tok_i.code[GLYPH_W-1:0] + tok_i.base;
      end else begin
        s1_mode_d = MODE_ARRAY;
      end
    end
  end

  // stage 2: bounds check and memory read
  assign rd_inrange = !s1_idx_q[IDX_W-1] && (s1_idx_q < IDX_W'(used_words_i));
  assign rd_addr    = s1_idx_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    s1_mode_q    <= s1_mode_d;
    s1_hit_q     <= s1_hit_d;
    s1_glyph_q   <= s1_glyph_d;
    s1_base_q    <= tok_i.base;
    s1_idx_q     <= s1_idx_d;
    s2_mode_q    <= s1_mode_q;
    s2_hit_q     <= s1_hit_q;
    s2_glyph_q   <= s1_glyph_q;
    s2_base_q    <= s1_base_q;
    s2_inrange_q <= rd_inrange;
    s2_rd_q      <= mem_q[rd_addr];
  end

  // stage 3: final glyph; a zero array word stays zero
  always_comb begin
    res_d.range_hit = s2_hit_q;
    unique case (s2_mode_q)
      MODE_DIRECT: res_d.glyph_id = s2_glyph_q;
      MODE_ARRAY:  res_d.glyph_id = (s2_inrange_q && (s2_rd_q != '0)) ?
                                    s2_rd_q + s2_base_q : '0;
      default:     res_d.glyph_id = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= tok_i.valid;
      s2_valid_q <= s1_valid_q;
      if (s2_valid_q) begin
        res_valid_q <= 1'b1;
      end else if (res_take_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### hdl/cgl_checker.sv
// ----------------------------------------------------------------------------
// cgl_checker
// Port-level checks on the glyph lookup request and response channels.
// ----------------------------------------------------------------------------
module cgl_checker import cgl_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input req_e req_type_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i
);

  logic req_xfer, lookup_xfer;

  assign req_xfer    = req_valid_i && req_ready_i;
  assign lookup_xfer = req_xfer && (req_type_i == REQ_LOOKUP);

  // one lookup in flight: no new request right after a lookup transfer
  a_lookup_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup_xfer |=> !req_ready_i)
    else $error("request taken right after a lookup transfer");

  // a response only shows up while a lookup was outstanding
  a_rsp_from_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(!req_ready_i))
    else $error("response appeared with no lookup outstanding");

  // writes produce no response
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_xfer && (req_type_i != REQ_LOOKUP) && !rsp_valid_i) |=> !rsp_valid_i)
    else $error("response produced by a write");

  // a pending response is held until transferred
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i)
    else $error("response dropped before transfer");

endmodule

bind cmap_glyph_lookup cgl_checker u_cgl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_type_i  (req_i.data.req_type),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready)
);
